// ===== hdl/cs2rgb_pkg.sv =====
package cs2rgb_pkg;

  // input field widths
  localparam int FUNC_W = 2;
  localparam int CHAN_W = 8;
  localparam int INK_W  = 14;
  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;

  // scale constants of the color formulas
  localparam int INK_FULL   = 10000;
  localparam int PCT_FULL   = 100;
  localparam int DEG_SECTOR = 60;
  localparam int CHAN_MAX   = 255;

  // internal widths
  localparam int LS_W   = 14;   // product of two percents, up to 10000
  localparam int HN_W   = 21;   // hue-mode terms, up to 1200000
  localparam int NUM_W  = 27;   // channel numerator, up to 1e8
  localparam int ACC_W  = 35;   // 255 * numerator plus rounding bias
  localparam int V_W    = 27;   // numerator after the power-of-two part of the divisor
  localparam int REC_W  = 27;   // reciprocal width
  localparam int DIV_W  = 19;   // odd part of the divisor
  localparam int PRD_W  = 28;   // (q + 1) * divisor

  // ink modes divide by 1e8 = 2^8 * 390625
  // hue modes divide by 1200000 = 2^7 * 9375
  localparam int INK_BIAS  = 50000000;
  localparam int HUE_BIAS  = 600000;
  localparam int INK_SHIFT = 8;
  localparam int HUE_SHIFT = 7;
  localparam logic [DIV_W-1:0] INK_DIV = 19'd390625;
  localparam logic [DIV_W-1:0] HUE_DIV = 19'd9375;
  localparam int RECIP_SHIFT = 40;
  // floor(2^40 / divisor)
  localparam logic [REC_W-1:0] INK_RECIP = 27'd2814749;
  localparam logic [REC_W-1:0] HUE_RECIP = 27'd117281240;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RGB  = 2'd0,
    FUNC_CMYK = 2'd1,
    FUNC_HSV  = 2'd2,
    FUNC_HSL  = 2'd3
  } func_t;

  // word handed from the numerator pipeline to the divider pipeline
  typedef struct packed {
    logic                   ink;
    logic                   force_en;
    logic [2:0][CHAN_W-1:0] force_rgb;
    logic [2:0][V_W-1:0]    v;
  } mid_t;

endpackage

// ===== hdl/cs2rgb_if.sv =====
interface cs2rgb_in_if;
  logic                           valid;
  logic                           ready;
  logic [cs2rgb_pkg::FUNC_W-1:0]  func;
  logic [cs2rgb_pkg::CHAN_W-1:0]  red_in;
  logic [cs2rgb_pkg::CHAN_W-1:0]  green_in;
  logic [cs2rgb_pkg::CHAN_W-1:0]  blue_in;
  logic [cs2rgb_pkg::INK_W-1:0]   cyan;
  logic [cs2rgb_pkg::INK_W-1:0]   magenta;
  logic [cs2rgb_pkg::INK_W-1:0]   yellow;
  logic [cs2rgb_pkg::INK_W-1:0]   key_black;
  logic [cs2rgb_pkg::HUE_W-1:0]   hue;
  logic [cs2rgb_pkg::PCT_W-1:0]   saturation;
  logic [cs2rgb_pkg::PCT_W-1:0]   level;

  modport source (
    output valid, func, red_in, green_in, blue_in, cyan, magenta, yellow, key_black,
           hue, saturation, level,
    input  ready
  );
  modport sink (
    input  valid, func, red_in, green_in, blue_in, cyan, magenta, yellow, key_black,
           hue, saturation, level,
    output ready
  );
endinterface

interface cs2rgb_out_if;
  logic                           valid;
  logic                           ready;
  logic [cs2rgb_pkg::CHAN_W-1:0]  red;
  logic [cs2rgb_pkg::CHAN_W-1:0]  green;
  logic [cs2rgb_pkg::CHAN_W-1:0]  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== hdl/color_space_to_rgb_converter.sv =====
// Converts one color word per clock to 8-bit red, green and blue. The func field picks
// the input space: rgb pass-through, cmyk in units of 1/10000, hsv or hsl with hue in
// degrees and percent saturation and value or lightness. Percent inputs above 100 and
// inks above 10000 saturate; a hue of 360 or more gives black in the hue modes. Every
// channel is the exact rational result rounded half up. The block is a 7-stage pipeline, and
// one word is accepted every cycle that the pipeline is not blocked. The divider stages
// replace the rounding division by a constant-reciprocal multiply and a one-step
// correction, each in a register stage of its own. Each stage has its own valid bit and
// ready, so a stall at the output fills bubbles first and drops or repeats nothing.
module color_space_to_rgb_converter (
  input  logic         clk,
  input  logic         rst_n,
  cs2rgb_in_if.sink    in_ch,
  cs2rgb_out_if.source out_ch
);

  // handoff between the numerator stages and the divider stages
  logic             mid_valid;
  logic             mid_ready;
  cs2rgb_pkg::mid_t mid;

  // stages 1 to 4: saturate, sector and chroma terms, numerators, bias and scale
  cs2rgb_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  // stages 5 to 7: reciprocal estimate, correction bound, output register
  cs2rgb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid),
    .out_ch    (out_ch)
  );

endmodule

// ===== hdl/cs2rgb_prep.sv =====
module cs2rgb_prep (
  input  logic               clk,
  input  logic               rst_n,
  cs2rgb_in_if.sink          in_ch,
  output logic               mid_valid,
  input  logic               mid_ready,
  output cs2rgb_pkg::mid_t   mid
);

  localparam int NS = 4;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;

  // stage 1: saturate, hue sector and triangle, percent product
  logic                                          s1_ink_r, s1_hsl_r, s1_force_r;
  logic [2:0][cs2rgb_pkg::CHAN_W-1:0]            s1_frgb_r;
  logic [2:0][cs2rgb_pkg::INK_W-1:0]             s1_a_r;
  logic [cs2rgb_pkg::INK_W-1:0]                  s1_b_r;
  logic [2:0]                                    s1_sector_r;
  logic [5:0]                                    s1_tri_r;
  logic [cs2rgb_pkg::PCT_W-1:0]                  s1_lev_r;
  logic [cs2rgb_pkg::LS_W-1:0]                   s1_ls_r;

  // stage 2: chroma, second component, offset, ink products
  logic                                          s2_ink_r, s2_force_r;
  logic [2:0][cs2rgb_pkg::CHAN_W-1:0]            s2_frgb_r;
  logic [2:0]                                    s2_sector_r;
  logic [2:0][cs2rgb_pkg::NUM_W-1:0]             s2_prod_r;
  logic [cs2rgb_pkg::HN_W-1:0]                   s2_c_r, s2_x_r, s2_mm_r;

  // stage 3: channel numerators
  logic                                          s3_ink_r, s3_force_r;
  logic [2:0][cs2rgb_pkg::CHAN_W-1:0]            s3_frgb_r;
  logic [2:0][cs2rgb_pkg::NUM_W-1:0]             s3_n_r;

  // stage 4: scaled and biased numerators
  cs2rgb_pkg::mid_t                              s4_r;

  // per-stage ready so bubbles close up under a stall
  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || mid_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ch.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_ch.valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // ---- stage 1 logic
  cs2rgb_pkg::func_t                 func_c;
  logic [cs2rgb_pkg::PCT_W-1:0]      sat_c, lev_c;
  logic [cs2rgb_pkg::PCT_W:0]        span_c, fac_c;
  logic [6:0]                        hm_c;
  logic [5:0]                        tri_c;
  logic [2:0]                        sector_c;
  logic [2:0][cs2rgb_pkg::INK_W-1:0] a_c;
  logic [cs2rgb_pkg::INK_W-1:0]      b_c;
  logic [cs2rgb_pkg::INK_W-1:0]      ink_v [3];

  function automatic logic [cs2rgb_pkg::INK_W-1:0] ink_left(
    input logic [cs2rgb_pkg::INK_W-1:0] x
  );
    logic [cs2rgb_pkg::INK_W-1:0] full;
    full = cs2rgb_pkg::INK_W'(cs2rgb_pkg::INK_FULL);
    return (x > full) ? '0 : full - x;
  endfunction

  always_comb begin
    func_c = cs2rgb_pkg::func_t'(in_ch.func);
    sat_c  = (in_ch.saturation > cs2rgb_pkg::PCT_W'(cs2rgb_pkg::PCT_FULL))
             ? cs2rgb_pkg::PCT_W'(cs2rgb_pkg::PCT_FULL) : in_ch.saturation;
    lev_c  = (in_ch.level > cs2rgb_pkg::PCT_W'(cs2rgb_pkg::PCT_FULL))
             ? cs2rgb_pkg::PCT_W'(cs2rgb_pkg::PCT_FULL) : in_ch.level;
    // span = 100 - |2l - 100|
    if (lev_c >= cs2rgb_pkg::PCT_W'(cs2rgb_pkg::PCT_FULL / 2)) begin
      span_c = (cs2rgb_pkg::PCT_W+1)'(2 * cs2rgb_pkg::PCT_FULL) - {lev_c, 1'b0};
    end else begin
      span_c = {lev_c, 1'b0};
    end
    fac_c = (func_c == cs2rgb_pkg::FUNC_HSL) ? span_c : {1'b0, lev_c};

    // hue sector and position inside a pair of sectors
    if (in_ch.hue < 9'(2 * cs2rgb_pkg::DEG_SECTOR)) begin
      hm_c = in_ch.hue[6:0];
    end else if (in_ch.hue < 9'(4 * cs2rgb_pkg::DEG_SECTOR)) begin
      hm_c = 7'(in_ch.hue - 9'(2 * cs2rgb_pkg::DEG_SECTOR));
    end else begin
      hm_c = 7'(in_ch.hue - 9'(4 * cs2rgb_pkg::DEG_SECTOR));
    end
    tri_c = (hm_c >= 7'(cs2rgb_pkg::DEG_SECTOR))
            ? 6'(7'(2 * cs2rgb_pkg::DEG_SECTOR) - hm_c) : hm_c[5:0];
    if (in_ch.hue < 9'(cs2rgb_pkg::DEG_SECTOR))          sector_c = 3'd0;
    else if (in_ch.hue < 9'(2 * cs2rgb_pkg::DEG_SECTOR)) sector_c = 3'd1;
    else if (in_ch.hue < 9'(3 * cs2rgb_pkg::DEG_SECTOR)) sector_c = 3'd2;
    else if (in_ch.hue < 9'(4 * cs2rgb_pkg::DEG_SECTOR)) sector_c = 3'd3;
    else if (in_ch.hue < 9'(5 * cs2rgb_pkg::DEG_SECTOR)) sector_c = 3'd4;
    else                                                  sector_c = 3'd5;

    ink_v[0] = in_ch.cyan;
    ink_v[1] = in_ch.magenta;
    ink_v[2] = in_ch.yellow;
    for (int i = 0; i < 3; i++) begin
      a_c[i] = ink_left(ink_v[i]);
    end
    b_c = ink_left(in_ch.key_black);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_ink_r    <= (func_c == cs2rgb_pkg::FUNC_CMYK);
      s1_hsl_r    <= (func_c == cs2rgb_pkg::FUNC_HSL);
      // pass-through and out-of-range hue bypass the arithmetic
      s1_force_r  <= (func_c == cs2rgb_pkg::FUNC_RGB) ||
                     (!in_ch.func[1] ? 1'b0 :
                      (in_ch.hue >= 9'(6 * cs2rgb_pkg::DEG_SECTOR)));
      s1_frgb_r   <= (func_c == cs2rgb_pkg::FUNC_RGB)
                     ? {in_ch.blue_in, in_ch.green_in, in_ch.red_in} : '0;
      s1_a_r      <= a_c;
      s1_b_r      <= b_c;
      s1_sector_r <= sector_c;
      s1_tri_r    <= tri_c;
      s1_lev_r    <= lev_c;
      s1_ls_r     <= cs2rgb_pkg::LS_W'(fac_c) * cs2rgb_pkg::LS_W'(sat_c);
    end
  end

  // ---- stage 2 logic
  // hue modes share one scale of 1200000: hsv terms are doubled
  logic [cs2rgb_pkg::HN_W-1:0] c2_c, mm_sub_c;

  always_comb begin
    c2_c     = cs2rgb_pkg::HN_W'(s1_ls_r)
               * cs2rgb_pkg::HN_W'(2 * cs2rgb_pkg::DEG_SECTOR);
    mm_sub_c = s1_hsl_r ? cs2rgb_pkg::HN_W'(s1_ls_r)
                          * cs2rgb_pkg::HN_W'(cs2rgb_pkg::DEG_SECTOR)
                        : c2_c;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_ink_r    <= s1_ink_r;
      s2_force_r  <= s1_force_r;
      s2_frgb_r   <= s1_frgb_r;
      s2_sector_r <= s1_sector_r;
      for (int i = 0; i < 3; i++) begin
        s2_prod_r[i] <= cs2rgb_pkg::NUM_W'(s1_a_r[i]) * cs2rgb_pkg::NUM_W'(s1_b_r);
      end
      s2_c_r  <= c2_c;
      s2_x_r  <= cs2rgb_pkg::HN_W'(s1_ls_r) * cs2rgb_pkg::HN_W'({s1_tri_r, 1'b0});
      s2_mm_r <= cs2rgb_pkg::HN_W'(s1_lev_r)
                 * cs2rgb_pkg::HN_W'(2 * cs2rgb_pkg::PCT_FULL * cs2rgb_pkg::DEG_SECTOR)
                 - mm_sub_c;
    end
  end

  // ---- stage 3 logic: place chroma and second component by sector
  logic [2:0][cs2rgb_pkg::HN_W-1:0] comp_c;

  always_comb begin
    comp_c = '0;
    case (s2_sector_r)
      3'd0: begin comp_c[0] = s2_c_r; comp_c[1] = s2_x_r; end
      3'd1: begin comp_c[0] = s2_x_r; comp_c[1] = s2_c_r; end
      3'd2: begin comp_c[1] = s2_c_r; comp_c[2] = s2_x_r; end
      3'd3: begin comp_c[1] = s2_x_r; comp_c[2] = s2_c_r; end
      3'd4: begin comp_c[0] = s2_x_r; comp_c[2] = s2_c_r; end
      default: begin comp_c[0] = s2_c_r; comp_c[2] = s2_x_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_ink_r   <= s2_ink_r;
      s3_force_r <= s2_force_r;
      s3_frgb_r  <= s2_frgb_r;
      for (int i = 0; i < 3; i++) begin
        s3_n_r[i] <= s2_ink_r ? s2_prod_r[i]
                     : cs2rgb_pkg::NUM_W'(comp_c[i]) + cs2rgb_pkg::NUM_W'(s2_mm_r);
      end
    end
  end

  // ---- stage 4 logic: u = 255 * n + half divisor, drop the power-of-two part
  logic [2:0][cs2rgb_pkg::ACC_W-1:0] u_c;
  logic [2:0][cs2rgb_pkg::V_W-1:0]   v_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_c[i] = {cs2rgb_pkg::ACC_W'(s3_n_r[i]) << 8}
               - cs2rgb_pkg::ACC_W'(s3_n_r[i])
               + (s3_ink_r ? cs2rgb_pkg::ACC_W'(cs2rgb_pkg::INK_BIAS)
                           : cs2rgb_pkg::ACC_W'(cs2rgb_pkg::HUE_BIAS));
      v_c[i] = s3_ink_r ? cs2rgb_pkg::V_W'(u_c[i] >> cs2rgb_pkg::INK_SHIFT)
                        : cs2rgb_pkg::V_W'(u_c[i] >> cs2rgb_pkg::HUE_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_r.ink       <= s3_ink_r;
      s4_r.force_en  <= s3_force_r;
      s4_r.force_rgb <= s3_frgb_r;
      s4_r.v         <= v_c;
    end
  end

  assign mid_valid = vld_r[NS-1];
  assign mid       = s4_r;

endmodule

// ===== hdl/cs2rgb_div.sv =====
module cs2rgb_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mid_valid,
  output logic               mid_ready,
  input  cs2rgb_pkg::mid_t   mid,
  cs2rgb_out_if.source       out_ch
);

  localparam int NS = 3;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;

  // stage 5: quotient estimate from the reciprocal
  logic                                     s5_ink_r, s5_force_r;
  logic [2:0][cs2rgb_pkg::CHAN_W-1:0]       s5_frgb_r;
  logic [2:0][cs2rgb_pkg::V_W-1:0]          s5_v_r;
  logic [2:0][cs2rgb_pkg::CHAN_W-1:0]       s5_q_r;

  // stage 6: bound for the one-step correction
  logic                                     s6_force_r;
  logic [2:0][cs2rgb_pkg::CHAN_W-1:0]       s6_frgb_r;
  logic [2:0][cs2rgb_pkg::V_W-1:0]          s6_v_r;
  logic [2:0][cs2rgb_pkg::CHAN_W-1:0]       s6_q_r;
  logic [2:0][cs2rgb_pkg::PRD_W-1:0]        s6_p_r;

  // stage 7: output register
  logic [2:0][cs2rgb_pkg::CHAN_W-1:0]       s7_rgb_r;

  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign mid_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= mid_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // estimate is exact or one low
  localparam int MUL_W = cs2rgb_pkg::V_W + cs2rgb_pkg::REC_W;

  logic [cs2rgb_pkg::REC_W-1:0]  recip_c;
  logic [2:0][MUL_W-1:0]         mul_c;

  always_comb begin
    recip_c = mid.ink ? cs2rgb_pkg::INK_RECIP : cs2rgb_pkg::HUE_RECIP;
    for (int i = 0; i < 3; i++) begin
      mul_c[i] = MUL_W'(mid.v[i]) * MUL_W'(recip_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s5_ink_r   <= mid.ink;
      s5_force_r <= mid.force_en;
      s5_frgb_r  <= mid.force_rgb;
      s5_v_r     <= mid.v;
      for (int i = 0; i < 3; i++) begin
        s5_q_r[i] <= mul_c[i][cs2rgb_pkg::RECIP_SHIFT +: cs2rgb_pkg::CHAN_W];
      end
    end
  end

  logic [cs2rgb_pkg::DIV_W-1:0] div_c;

  assign div_c = s5_ink_r ? cs2rgb_pkg::INK_DIV : cs2rgb_pkg::HUE_DIV;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s6_force_r <= s5_force_r;
      s6_frgb_r  <= s5_frgb_r;
      s6_v_r     <= s5_v_r;
      s6_q_r     <= s5_q_r;
      for (int i = 0; i < 3; i++) begin
        s6_p_r[i] <= cs2rgb_pkg::PRD_W'((cs2rgb_pkg::CHAN_W+1)'(s5_q_r[i]) + 9'd1)
                     * cs2rgb_pkg::PRD_W'(div_c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        if (s6_force_r) begin
          s7_rgb_r[i] <= s6_frgb_r[i];
        end else if (cs2rgb_pkg::PRD_W'(s6_v_r[i]) >= s6_p_r[i]) begin
          s7_rgb_r[i] <= s6_q_r[i] + 8'd1;
        end else begin
          s7_rgb_r[i] <= s6_q_r[i];
        end
      end
    end
  end

  assign out_ch.valid = vld_r[NS-1];
  assign out_ch.red   = s7_rgb_r[0];
  assign out_ch.green = s7_rgb_r[1];
  assign out_ch.blue  = s7_rgb_r[2];

endmodule
